// ===== hdl/iil_pkg.sv =====
// ----------------------------------------------------------------------------
// iil_pkg
// shared types and constants for the indexed integer list
// ----------------------------------------------------------------------------
package iil_pkg;

  // number of list entries, tied to the 4-bit position and 5-bit count fields
  localparam int unsigned CAPACITY = 16;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned DATA_W   = 32;

  typedef enum logic [2:0] {
    KIND_APPEND = 3'd0,
    KIND_INSERT = 3'd1,
    KIND_READ   = 3'd2,
    KIND_DELETE = 3'd3,
    KIND_CLEAR  = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_FULL   = 2'd1,
    STATUS_BADPOS = 2'd2
  } status_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

  typedef struct packed {
    logic [2:0]               kind;
    logic signed [DATA_W-1:0] item_value;
    logic [IDX_W-1:0]         position;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    logic [1:0]               status;
    logic [CNT_W-1:0]         entry_count;
  } rsp_t;

  // controller to datapath commands
  typedef struct packed {
    logic take;   // capture the incoming item
    logic exec;   // run the captured item and load the result register
  } cmd_t;

endpackage

// ===== hdl/iil_ctrl.sv =====
// ----------------------------------------------------------------------------
// iil_ctrl
// handshake controller: capture, execute, result hand-off
// ----------------------------------------------------------------------------
module iil_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output iil_pkg::cmd_t cmd_o
);

  iil_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            out_free;

  // result register can take a new result this cycle
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      iil_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = iil_pkg::ST_EXEC;
      end
      iil_pkg::ST_EXEC: begin
        if (out_free) state_d = iil_pkg::ST_IDLE;
      end
      default: state_d = iil_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.take = 1'b0;
    cmd_o.exec = 1'b0;
    in_stall_o = 1'b1;
    case (state_q)
      iil_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.take = in_valid_i;
      end
      iil_pkg::ST_EXEC: begin
        cmd_o.exec = out_free;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  assign out_valid_d = cmd_o.exec || (out_valid_q && out_stall_i);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= iil_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_take_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.take |=> state_q == iil_pkg::ST_EXEC)
    else $error("captured item did not move to execute");

  a_exec_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.exec |=> out_valid_q)
    else $error("executed item produced no result");

  a_no_exec_over_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !cmd_o.exec)
    else $error("result overwritten while stalled");

  a_result_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> out_valid_q)
    else $error("stalled result dropped");

endmodule

// ===== hdl/iil_datapath.sv =====
// ----------------------------------------------------------------------------
// iil_datapath
// request register, shifting row of entry cells, count and result register
// ----------------------------------------------------------------------------
module iil_datapath (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  iil_pkg::cmd_t cmd_i,
  input  iil_pkg::req_t req_i,
  output iil_pkg::rsp_t rsp_o
);

  localparam int unsigned CAP = iil_pkg::CAPACITY;
  localparam int unsigned IW  = iil_pkg::IDX_W;
  localparam int unsigned CW  = iil_pkg::CNT_W;
  localparam int unsigned DW  = iil_pkg::DATA_W;

  iil_pkg::req_t    req_q;
  logic [DW-1:0]    cells_q [CAP];
  logic [DW-1:0]    cells_d [CAP];
  logic [CW-1:0]    count_q, count_d;
  iil_pkg::rsp_t    rsp_q, rsp_d;

  logic             is_full;
  logic             pos_bad;
  logic [IW-1:0]    ins_pos;
  logic [DW-1:0]    sel_value;

  assign is_full   = (count_q == CW'(CAP));
  assign pos_bad   = ({1'b0, req_q.position} >= count_q);
  assign sel_value = cells_q[req_q.position];
  // append, or insert at or past the end, lands on the first free cell
  assign ins_pos   = ((req_q.kind == iil_pkg::KIND_APPEND) || pos_bad)
                     ? count_q[IW-1:0] : req_q.position;

  always_comb begin
    cells_d = cells_q;
    count_d = count_q;
    rsp_d.read_value = '0;
    rsp_d.status     = iil_pkg::STATUS_OK;

    case (req_q.kind)
      iil_pkg::KIND_APPEND,
      iil_pkg::KIND_INSERT: begin
        if (is_full) begin
          rsp_d.status = iil_pkg::STATUS_FULL;
        end else begin
          if (ins_pos == '0) cells_d[0] = req_q.item_value;
          for (int i = 1; i < CAP; i++) begin
            if (IW'(i) == ins_pos) cells_d[i] = req_q.item_value;
            else if (IW'(i) > ins_pos) cells_d[i] = cells_q[i-1];
          end
          count_d = count_q + CW'(1);
        end
      end
      iil_pkg::KIND_READ: begin
        if (pos_bad) rsp_d.status = iil_pkg::STATUS_BADPOS;
        else rsp_d.read_value = sel_value;
      end
      iil_pkg::KIND_DELETE: begin
        if (pos_bad) begin
          rsp_d.status = iil_pkg::STATUS_BADPOS;
        end else begin
          rsp_d.read_value = sel_value;
          for (int i = 0; i < CAP - 1; i++) begin
            if (IW'(i) >= req_q.position) cells_d[i] = cells_q[i+1];
          end
          count_d = count_q - CW'(1);
        end
      end
      iil_pkg::KIND_CLEAR: begin
        count_d = '0;
      end
      default: begin
        count_d = count_q;
      end
    endcase

    rsp_d.entry_count = count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.exec) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) req_q <= req_i;
    if (cmd_i.exec) begin
      cells_q <= cells_d;
      rsp_q   <= rsp_d;
    end
  end

  assign rsp_o = rsp_q;

endmodule

// ===== hdl/indexed_integer_list_core.sv =====
// ----------------------------------------------------------------------------
// indexed_integer_list_core
// ordered list of signed 32-bit integers with append, insert, read, delete
// and clear by position
// ----------------------------------------------------------------------------
// The list lives in a row of 16 register cells that shift up on insert and
// down on delete, so every request runs on the whole row at once no matter
// where it lands. An item is first captured into the request register, then
// run on the cell row while the result register is loaded. The next item
// is accepted in the cycle after execute; while an item is pending, a new
// one is stalled. A result waits in the output register while the far side
// stalls; a captured item only executes once that register is free. Every
// item gives exactly one result: value read or removed (zero otherwise), a
// status (ok, full, bad position) and the count after the operation. Kinds
// 5 to 7 change nothing and report ok.
// ----------------------------------------------------------------------------
module indexed_integer_list_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  // request channel
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  iil_pkg::req_t in_req_i,
  // result channel
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output iil_pkg::rsp_t out_rsp_o
);

  // commands from the controller to the datapath
  iil_pkg::cmd_t cmd;

  // state machine: capture, then execute when the result register is free
  iil_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // cell row, count and result register
  iil_datapath u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .req_i  (in_req_i),
    .rsp_o  (out_rsp_o)
  );

endmodule

// ===== tb/indexed_integer_list_checker.sv =====
// ----------------------------------------------------------------------------
// indexed_integer_list_checker
// scoreboard for the indexed integer list: shadows the list on every
// accepted request and compares every accepted result in order
// ----------------------------------------------------------------------------
module indexed_integer_list_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_stall_i,
  input  iil_pkg::req_t in_req_i,
  input  logic          out_valid_i,
  input  logic          out_stall_i,
  input  iil_pkg::rsp_t out_rsp_i,
  output int unsigned   error_count_o,
  output int unsigned   pending_o
);

  localparam int unsigned CNT_W = iil_pkg::CNT_W;

  // shadow copy of the list contents and length
  logic signed [iil_pkg::DATA_W-1:0] shadow_list [iil_pkg::CAPACITY];
  int unsigned                       shadow_len;
  iil_pkg::rsp_t                     expected_rsp_q [$];

  // run one request on the shadow list and return the result it must give
  function automatic iil_pkg::rsp_t apply_request(input iil_pkg::req_t r);
    iil_pkg::rsp_t res;
    int unsigned   slot;
    int unsigned   i;
    res        = '0;
    res.status = iil_pkg::STATUS_OK;
    case (r.kind)
      iil_pkg::KIND_APPEND, iil_pkg::KIND_INSERT: begin
        if (shadow_len >= iil_pkg::CAPACITY) begin
          res.status = iil_pkg::STATUS_FULL;
        end else begin
          // append, or insert past the end, lands after the last entry
          if (r.kind == iil_pkg::KIND_APPEND || r.position >= shadow_len) begin
            slot = shadow_len;
          end else begin
            slot = r.position;
          end
          for (i = shadow_len; i > slot; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[slot] = r.item_value;
          shadow_len++;
        end
      end
      iil_pkg::KIND_READ: begin
        if (r.position < shadow_len) res.read_value = shadow_list[r.position];
        else res.status = iil_pkg::STATUS_BADPOS;
      end
      iil_pkg::KIND_DELETE: begin
        if (r.position < shadow_len) begin
          res.read_value = shadow_list[r.position];
          for (i = r.position; i + 1 < shadow_len; i++) shadow_list[i] = shadow_list[i+1];
          shadow_len--;
        end else begin
          res.status = iil_pkg::STATUS_BADPOS;
        end
      end
      iil_pkg::KIND_CLEAR: begin
        shadow_len = 0;
      end
      default: begin
        // unused kinds leave everything alone
      end
    endcase
    res.entry_count = CNT_W'(shadow_len);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    iil_pkg::rsp_t want;
    if (!rst_ni) begin
      shadow_len = 0;
      expected_rsp_q.delete();
    end else begin
      if (in_valid_i && !in_stall_i) expected_rsp_q.push_back(apply_request(in_req_i));
      if (out_valid_i && !out_stall_i) begin
        if (expected_rsp_q.size() == 0) begin
          $error("result with no request pending: value %0d status %0d count %0d",
                 out_rsp_i.read_value, out_rsp_i.status, out_rsp_i.entry_count);
          error_count_o++;
        end else begin
          want = expected_rsp_q.pop_front();
          if (out_rsp_i.read_value !== want.read_value) begin
            $error("read_value: expected %0d, got %0d", want.read_value,
                   out_rsp_i.read_value);
            error_count_o++;
          end
          if (out_rsp_i.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_rsp_i.status);
            error_count_o++;
          end
          if (out_rsp_i.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count,
                   out_rsp_i.entry_count);
            error_count_o++;
          end
        end
      end
    end
    pending_o = expected_rsp_q.size();
  end

endmodule

// ===== tb/indexed_integer_list_core_tb.sv =====
// ----------------------------------------------------------------------------
// indexed_integer_list_core_tb
// stimulus and verdict for the indexed integer list
// ----------------------------------------------------------------------------
// A short directed run walks the empty, front, back, past-the-end, full and
// unused-kind cases, then about 500 random requests follow in phases that
// fill, mix and drain the list. The sender works in bursts with random gaps
// and the receiver stalls in modes of its own. The checker beside the block
// predicts every result and counts mismatches.
// ----------------------------------------------------------------------------
module indexed_integer_list_core_tb;

  localparam int unsigned DATA_W   = iil_pkg::DATA_W;
  localparam int unsigned IDX_W    = iil_pkg::IDX_W;
  localparam int unsigned CAPACITY = iil_pkg::CAPACITY;

  localparam int unsigned RANDOM_ITEMS   = 500;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES  = 10;

  // kinds with no operation behind them
  localparam logic [2:0] KIND_RSVD_LO = 3'd5;
  localparam logic [2:0] KIND_RSVD_HI = 3'd7;

  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;

  // random phases steer the list through full and empty
  typedef enum int unsigned {
    PHASE_FILL  = 0,
    PHASE_MIX   = 1,
    PHASE_DRAIN = 2
  } phase_e;

  logic          clk_i;
  logic          rst_ni;
  logic          in_valid_i;
  logic          in_stall_o;
  iil_pkg::req_t in_req_i;
  logic          out_valid_o;
  logic          out_stall_i;
  iil_pkg::rsp_t out_rsp_o;
  int unsigned   error_count;
  int unsigned   pending_count;

  // requests left in the current sender burst
  int unsigned burst_left;
  // cycles in a row with no item moving on either channel
  int unsigned idle_cycles;

  indexed_integer_list_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

  indexed_integer_list_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .in_req_i      (in_req_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_rsp_i     (out_rsp_o),
    .error_count_o (error_count),
    .pending_o     (pending_count)
  );

  // 8 unit clock period
  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // watchdog: a hung handshake ends the run
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver: switches between free flow, coin-flip stalls and mostly stalled spans
  initial begin
    int unsigned mode;
    int unsigned span;
    out_stall_i = 1'b0;
    forever begin
      mode = $urandom_range(2, 0);
      span = $urandom_range(120, 20);
      repeat (span) begin
        @(negedge clk_i);
        case (mode)
          0:       out_stall_i <= 1'b0;
          1:       out_stall_i <= ($urandom_range(1, 0) == 1);
          default: out_stall_i <= ($urandom_range(9, 0) < 8);
        endcase
      end
    end
  end

  function automatic iil_pkg::req_t make_request(input logic [2:0] kind,
                                                 input logic signed [DATA_W-1:0] value,
                                                 input int unsigned pos);
    iil_pkg::req_t r;
    r.kind       = kind;
    r.item_value = value;
    r.position   = IDX_W'(pos);
    return r;
  endfunction

  // mostly full-range values, with the extremes mixed in
  function automatic logic signed [DATA_W-1:0] random_value();
    case ($urandom_range(19, 0))
      0:       return VAL_MAX;
      1:       return VAL_MIN;
      2:       return '0;
      3:       return -1;
      default: return $urandom;
    endcase
  endfunction

  // kind mix depends on the phase; positions lean low so they often hit
  function automatic iil_pkg::req_t random_request(input phase_e phase);
    int unsigned roll;
    logic [2:0]  kind;
    int unsigned pos;
    roll = $urandom_range(99, 0);
    case (phase)
      PHASE_FILL: begin
        if (roll < 45)      kind = iil_pkg::KIND_APPEND;
        else if (roll < 80) kind = iil_pkg::KIND_INSERT;
        else if (roll < 90) kind = iil_pkg::KIND_READ;
        else if (roll < 97) kind = iil_pkg::KIND_DELETE;
        else if (roll < 98) kind = iil_pkg::KIND_CLEAR;
        else                kind = 3'($urandom_range(KIND_RSVD_HI, KIND_RSVD_LO));
      end
      PHASE_MIX: begin
        if (roll < 20)      kind = iil_pkg::KIND_APPEND;
        else if (roll < 42) kind = iil_pkg::KIND_INSERT;
        else if (roll < 70) kind = iil_pkg::KIND_READ;
        else if (roll < 95) kind = iil_pkg::KIND_DELETE;
        else if (roll < 97) kind = iil_pkg::KIND_CLEAR;
        else                kind = 3'($urandom_range(KIND_RSVD_HI, KIND_RSVD_LO));
      end
      default: begin
        if (roll < 5)       kind = iil_pkg::KIND_APPEND;
        else if (roll < 10) kind = iil_pkg::KIND_INSERT;
        else if (roll < 30) kind = iil_pkg::KIND_READ;
        else if (roll < 95) kind = iil_pkg::KIND_DELETE;
        else if (roll < 97) kind = iil_pkg::KIND_CLEAR;
        else                kind = 3'($urandom_range(KIND_RSVD_HI, KIND_RSVD_LO));
      end
    endcase
    if ($urandom_range(1, 0) == 1) pos = $urandom_range(3, 0);
    else pos = $urandom_range(CAPACITY - 1, 0);
    return make_request(kind, random_value(), pos);
  endfunction

  // present one item, holding it until accepted; bursts end in a random gap
  task automatic send_request(input iil_pkg::req_t r);
    int unsigned gap;
    int unsigned roll;
    @(negedge clk_i);
    if (burst_left == 0) begin
      roll = $urandom_range(99, 0);
      if (roll < 30)      gap = 0;
      else if (roll < 85) gap = $urandom_range(4, 1);
      else                gap = $urandom_range(25, 5);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(16, 1);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // hold off the sender until every pending result has come back
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_count != 0) @(negedge clk_i);
  endtask

  initial begin
    int unsigned k;
    phase_e      phase;
    in_valid_i = 1'b0;
    in_req_i   = '0;
    burst_left = 0;
    rst_ni     = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    // empty list: read and delete are out of range
    send_request(make_request(iil_pkg::KIND_READ, '0, 0));
    send_request(make_request(iil_pkg::KIND_DELETE, '0, 0));
    // extremes at the back, a value at the front, insert past the end
    send_request(make_request(iil_pkg::KIND_APPEND, VAL_MAX, 0));
    send_request(make_request(iil_pkg::KIND_APPEND, VAL_MIN, 9));
    send_request(make_request(iil_pkg::KIND_INSERT, -1, 0));
    send_request(make_request(iil_pkg::KIND_INSERT, '0, CAPACITY - 1));
    send_request(make_request(iil_pkg::KIND_READ, '0, 0));
    send_request(make_request(iil_pkg::KIND_READ, '0, 4));
    // fill to capacity, alternating appends and mid-list inserts
    for (k = 4; k < CAPACITY; k++) begin
      if (k % 2 == 0) send_request(make_request(iil_pkg::KIND_APPEND, random_value(), 0));
      else send_request(make_request(iil_pkg::KIND_INSERT, random_value(), k / 2));
    end
    // full list refuses both kinds of insertion
    send_request(make_request(iil_pkg::KIND_APPEND, 32'sh1234_5678, 0));
    send_request(make_request(iil_pkg::KIND_INSERT, 32'sh0BAD_F00D, 0));
    // delete at the back, then at the front
    send_request(make_request(iil_pkg::KIND_DELETE, '0, CAPACITY - 1));
    send_request(make_request(iil_pkg::KIND_DELETE, '0, 0));
    // unused kinds change nothing
    send_request(make_request(KIND_RSVD_LO, VAL_MIN, CAPACITY - 1));
    send_request(make_request(KIND_RSVD_HI, VAL_MAX, 0));
    send_request(make_request(iil_pkg::KIND_CLEAR, '0, 0));
    wait_drained();

    // random part: 40-item phases cycle fill, mix, drain
    for (k = 0; k < RANDOM_ITEMS; k++) begin
      phase = phase_e'((k / 40) % 3);
      if (k == RANDOM_ITEMS / 2) wait_drained();
      send_request(random_request(phase));
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/iil_pkg.sv
hdl/iil_ctrl.sv
hdl/iil_datapath.sv
hdl/indexed_integer_list_core.sv
tb/indexed_integer_list_checker.sv
tb/indexed_integer_list_core_tb.sv
